/* sv/pts_pkg.sv */
// Shared types, codes and helpers for the pot trim binary search block.
// No dependencies; used by every module of the block.
`default_nettype none

package pts_pkg;

   // Field widths
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned CODE_W  = 10;

   // Input action codes
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_MEASURE = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_SET    = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // Finish status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL_LOW  = 2'd1;
   localparam logic [1:0] ST_ZERO_HIGH = 2'd2;
   localparam logic [1:0] ST_FAIL      = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_FULL_SCALE_MIN = 2'd0;
   localparam logic [1:0] REG_ZERO_SCALE_MAX = 2'd1;
   localparam logic [1:0] REG_WINDOW_HIGH    = 2'd2;
   localparam logic [1:0] REG_WINDOW_LOW     = 2'd3;

   // Register reset values
   localparam logic [VALUE_W-1:0] FULL_SCALE_MIN_RST = 16'd4000;
   localparam logic [VALUE_W-1:0] ZERO_SCALE_MAX_RST = 16'd1000;
   localparam logic [VALUE_W-1:0] WINDOW_HIGH_RST    = 16'd2600;
   localparam logic [VALUE_W-1:0] WINDOW_LOW_RST     = 16'd2400;

   typedef struct packed {
      logic               action;
      logic [VALUE_W-1:0] measured_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [CODE_W-1:0]  pot_code;
      logic [VALUE_W-1:0] reported_value;
      logic [1:0]         status;
      logic [CODE_W-1:0]  trim_code;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] full_scale_min;
      logic [VALUE_W-1:0] zero_scale_max;
      logic [VALUE_W-1:0] window_high;
      logic [VALUE_W-1:0] window_low;
   } cfg_type;

   // Results of one item: zero, one or two beats
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_out_type;

   function automatic rsp_type make_rsp(
      input logic [1:0]         kind,
      input logic [CODE_W-1:0]  pot_code,
      input logic [VALUE_W-1:0] reported_value,
      input logic [1:0]         status,
      input logic [CODE_W-1:0]  trim_code,
      input logic               last
   );
      rsp_type r;
      r.kind           = kind;
      r.pot_code       = pot_code;
      r.reported_value = reported_value;
      r.status         = status;
      r.trim_code      = trim_code;
      r.last           = last;
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/pts_core.sv */
// Calibration sequencer: phase and search bounds, results of one item per cycle while fire is held.
// Depends on pts_pkg.
`default_nettype none

module pts_core #(
   parameter int unsigned POT_MAX_CODE = 1023
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire pts_pkg::req_type      item,
   input  wire pts_pkg::cfg_type      cfg,
   output pts_pkg::step_out_type      step_out
);

   localparam int unsigned BW = $clog2(POT_MAX_CODE + 1);
   localparam int unsigned CW = pts_pkg::CODE_W;
   localparam logic [BW-1:0] MAX_C = BW'(POT_MAX_CODE);
   localparam logic [BW-1:0] ONE_C = BW'(1);

   typedef enum logic [1:0] {PH_IDLE, PH_FULL, PH_ZERO, PH_SEARCH} phase_type;

   phase_type     phase_ff, phase_in;
   logic [BW-1:0] lower_ff, lower_in;
   logic [BW-1:0] upper_ff, upper_in;
   logic [BW-1:0] probe_ff, probe_in;

   // Search bounds for the next probe, midpoint and narrow test
   logic [BW-1:0] srch_lo, srch_hi, diff;
   logic [BW:0]   sum;
   logic [BW-1:0] mid;
   logic          narrow;
   pts_pkg::rsp_type probe_rsp;

   logic [pts_pkg::VALUE_W-1:0] m;

   // Bound to code field, zero-extended or cut to the field width
   function automatic logic [CW-1:0] to_code(input logic [BW-1:0] v);
      logic [BW+CW-1:0] wide;
      wide = {{CW{1'b0}}, v};
      return wide[CW-1:0];
   endfunction

   assign m = item.measured_value;

   // Bounds that the next probe uses
   always_comb begin
      srch_lo = lower_ff;
      srch_hi = upper_ff;
      if (phase_ff == PH_ZERO) begin
         srch_lo = ONE_C;
         srch_hi = MAX_C;
      end else if (m >= cfg.window_high) begin
         srch_hi = probe_ff;
      end else if (m <= cfg.window_low) begin
         srch_lo = probe_ff;
      end
   end

   assign diff   = srch_hi - srch_lo;
   assign narrow = (diff <= ONE_C);
   assign sum    = {1'b0, srch_hi} + {1'b0, srch_lo};
   assign mid    = sum[BW:1];
   assign probe_rsp = narrow
      ? pts_pkg::make_rsp(pts_pkg::KIND_DONE, '0, '0, pts_pkg::ST_FAIL, '0, 1'b1)
      : pts_pkg::make_rsp(pts_pkg::KIND_SET, to_code(mid), '0, 2'd0, '0, 1'b1);

   // Next state and results of the item
   always_comb begin
      phase_in = phase_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      probe_in = probe_ff;
      step_out = '0;
      if (item.action == pts_pkg::ACT_START) begin
         lower_in = ONE_C;
         upper_in = MAX_C;
         probe_in = '0;
         phase_in = PH_FULL;
         step_out.count = 2'd1;
         step_out.first = pts_pkg::make_rsp(pts_pkg::KIND_SET, to_code(MAX_C), '0, 2'd0,
                                            '0, 1'b1);
      end else begin
         case (phase_ff)
            PH_FULL: begin
               step_out.count = 2'd1;
               if (m < cfg.full_scale_min) begin
                  phase_in = PH_IDLE;
                  step_out.first = pts_pkg::make_rsp(pts_pkg::KIND_DONE, '0, '0,
                                                     pts_pkg::ST_FULL_LOW, '0, 1'b1);
               end else begin
                  phase_in = PH_ZERO;
                  step_out.first = pts_pkg::make_rsp(pts_pkg::KIND_SET, to_code(ONE_C), '0,
                                                     2'd0, '0, 1'b1);
               end
            end
            PH_ZERO: begin
               step_out.count = 2'd1;
               if (m > cfg.zero_scale_max) begin
                  phase_in = PH_IDLE;
                  step_out.first = pts_pkg::make_rsp(pts_pkg::KIND_DONE, '0, '0,
                                                     pts_pkg::ST_ZERO_HIGH, '0, 1'b1);
               end else begin
                  lower_in       = srch_lo;
                  upper_in       = srch_hi;
                  probe_in       = narrow ? probe_ff : mid;
                  phase_in       = narrow ? PH_IDLE : PH_SEARCH;
                  step_out.first = probe_rsp;
               end
            end
            PH_SEARCH: begin
               step_out.count = 2'd2;
               step_out.first = pts_pkg::make_rsp(pts_pkg::KIND_REPORT, '0, m, 2'd0, '0,
                                                  1'b0);
               if (m < cfg.window_high && m > cfg.window_low) begin
                  // inside the window: success with the current probe
                  phase_in = PH_IDLE;
                  step_out.second = pts_pkg::make_rsp(pts_pkg::KIND_DONE, '0, '0,
                                                      pts_pkg::ST_OK, to_code(probe_ff), 1'b1);
               end else begin
                  lower_in        = srch_lo;
                  upper_in        = srch_hi;
                  probe_in        = narrow ? probe_ff : mid;
                  phase_in        = narrow ? PH_IDLE : PH_SEARCH;
                  step_out.second = probe_rsp;
               end
            end
            default: begin
               // measurement while idle: dropped
               step_out.count = 2'd0;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         lower_ff <= ONE_C;
         upper_ff <= MAX_C;
         probe_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         probe_ff <= probe_in;
      end
   end

   // Probe stays strictly inside the bounds while searching
   a_probe_inside: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEARCH |-> (lower_ff < probe_ff) && (probe_ff < upper_ff))
      else $error("probe outside search bounds");

   // Bounds never cross
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      lower_ff < upper_ff)
      else $error("search bounds crossed");

   // Two beats only come from a measurement during the search
   a_two_beats: assert property (@(posedge clock) disable iff (reset)
      step_out.count == 2'd2 |-> phase_ff == PH_SEARCH && item.action == pts_pkg::ACT_MEASURE)
      else $error("two beats outside search");

endmodule

`default_nettype wire

/* sv/pts_out_buf.sv */
// Two-entry result buffer: loads all beats of one item, drains one per cycle unless stalled.
// Depends on pts_pkg.
`default_nettype none

module pts_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire pts_pkg::step_out_type step_out,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pts_pkg::rsp_type           rsp_data
);

   logic [1:0]       cnt_ff, cnt_in;
   pts_pkg::rsp_type slot0_ff, slot0_in;
   pts_pkg::rsp_type slot1_ff, slot1_in;
   logic             pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   // free once the last held beat leaves this cycle
   assign room      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   // Load or shift
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (fire) begin
         cnt_in   = step_out.count;
         slot0_in = step_out.first;
         slot1_in = step_out.second;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Loads only into a buffer that is draining empty
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      fire |-> (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop))
      else $error("load over pending beats");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("buffer count out of range");

   // A full buffer holds a non-final beat ahead of the final one
   a_last_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !slot0_ff.last && slot1_ff.last)
      else $error("last flag order broken");

endmodule

`default_nettype wire

/* sv/pot_trim_binary_search_top.sv */
// Pot trim calibration by bisection: input register, sequencer, result buffer.
// An accepted beat passes the input register and the result buffer before its first result beat.
// Throughput: one item per cycle when it yields one beat and rsp_stall is low; an item
// yielding two (search readings) holds the next one back, bounded by the single-port result buffer drain.
// Reset: synchronous, active high; phase idle, bounds 1 and max code, registers to defaults.
// Depends on pts_pkg, pts_core, pts_out_buf.
`default_nettype none

module pot_trim_binary_search_top #(
   parameter int unsigned POT_MAX_CODE = 1023
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire pts_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output pts_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [pts_pkg::VALUE_W-1:0]      csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   pts_pkg::req_type in_data_ff;
   pts_pkg::cfg_type cfg_ff, cfg_in;
   pts_pkg::step_out_type step_out;
   logic             room;
   logic             fire;
   logic             accept;

   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   // Input register
   assign in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pts_pkg::REG_FULL_SCALE_MIN: cfg_in.full_scale_min = csr_wdata;
            pts_pkg::REG_ZERO_SCALE_MAX: cfg_in.zero_scale_max = csr_wdata;
            pts_pkg::REG_WINDOW_HIGH:    cfg_in.window_high    = csr_wdata;
            pts_pkg::REG_WINDOW_LOW:     cfg_in.window_low     = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale_min <= pts_pkg::FULL_SCALE_MIN_RST;
         cfg_ff.zero_scale_max <= pts_pkg::ZERO_SCALE_MAX_RST;
         cfg_ff.window_high    <= pts_pkg::WINDOW_HIGH_RST;
         cfg_ff.window_low     <= pts_pkg::WINDOW_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pts_core #(
      .POT_MAX_CODE (POT_MAX_CODE)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (in_data_ff),
      .cfg      (cfg_ff),
      .step_out (step_out)
   );

   pts_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .step_out  (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Stall only with a held beat
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall without held beat");

   // A held beat that is not processed stays held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff)
      else $error("held beat lost");

endmodule

`default_nettype wire

/* tb/trim_checker.sv */
// Watches the request, result and register ports of the pot trim block,
// models the bisection sequencer and compares every result beat. Uses pts_pkg.
`timescale 1ns / 1ps

module trim_checker #(
   parameter int unsigned POT_MAX_CODE = 1023
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  pts_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  pts_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [pts_pkg::VALUE_W-1:0]  csr_wdata,
   output int unsigned                  mismatch_count,
   output int unsigned                  beats_pending
);

   typedef enum logic [1:0] {CAL_IDLE, CAL_FULL, CAL_ZERO, CAL_SEARCH} cal_phase_type;

   localparam logic [31:0] MAX_CODE = POT_MAX_CODE;

   // Model copy of registers and sequencer state
   logic [pts_pkg::VALUE_W-1:0] full_min, zero_max, win_high, win_low;
   cal_phase_type               cal_phase;
   logic [31:0]                 lo_bound, hi_bound, probe;

   pts_pkg::rsp_type expected_beats[$];
   int unsigned      faults = 0;

   assign mismatch_count = faults;

   // Next probe, or fail once the bounds are adjacent
   task automatic probe_or_give_up();
      pts_pkg::rsp_type b;
      b = '0;
      b.last = 1'b1;
      if (hi_bound - lo_bound <= 32'd1) begin
         cal_phase = CAL_IDLE;
         b.kind    = pts_pkg::KIND_DONE;
         b.status  = pts_pkg::ST_FAIL;
      end else begin
         probe      = (hi_bound + lo_bound) / 32'd2;
         cal_phase  = CAL_SEARCH;
         b.kind     = pts_pkg::KIND_SET;
         b.pot_code = probe[pts_pkg::CODE_W-1:0];
      end
      expected_beats.push_back(b);
   endtask

   // Expected beats for one accepted request
   task automatic predict_trim_step(input pts_pkg::req_type r);
      pts_pkg::rsp_type b;
      b = '0;
      b.last = 1'b1;
      if (r.action == pts_pkg::ACT_START) begin
         lo_bound   = 32'd1;
         hi_bound   = MAX_CODE;
         probe      = '0;
         cal_phase  = CAL_FULL;
         b.kind     = pts_pkg::KIND_SET;
         b.pot_code = MAX_CODE[pts_pkg::CODE_W-1:0];
         expected_beats.push_back(b);
      end else begin
         case (cal_phase)
            CAL_FULL: begin
               if (r.measured_value < full_min) begin
                  cal_phase = CAL_IDLE;
                  b.kind    = pts_pkg::KIND_DONE;
                  b.status  = pts_pkg::ST_FULL_LOW;
               end else begin
                  cal_phase  = CAL_ZERO;
                  b.kind     = pts_pkg::KIND_SET;
                  b.pot_code = pts_pkg::CODE_W'(1);
               end
               expected_beats.push_back(b);
            end
            CAL_ZERO: begin
               if (r.measured_value > zero_max) begin
                  cal_phase = CAL_IDLE;
                  b.kind    = pts_pkg::KIND_DONE;
                  b.status  = pts_pkg::ST_ZERO_HIGH;
                  expected_beats.push_back(b);
               end else begin
                  lo_bound = 32'd1;
                  hi_bound = MAX_CODE;
                  probe_or_give_up();
               end
            end
            CAL_SEARCH: begin
               b.kind           = pts_pkg::KIND_REPORT;
               b.reported_value = r.measured_value;
               b.last           = 1'b0;
               expected_beats.push_back(b);
               // high test wins when both hold
               if (r.measured_value >= win_high) begin
                  hi_bound = probe;
                  probe_or_give_up();
               end else if (r.measured_value <= win_low) begin
                  lo_bound = probe;
                  probe_or_give_up();
               end else begin
                  cal_phase   = CAL_IDLE;
                  b           = '0;
                  b.kind      = pts_pkg::KIND_DONE;
                  b.status    = pts_pkg::ST_OK;
                  b.trim_code = probe[pts_pkg::CODE_W-1:0];
                  b.last      = 1'b1;
                  expected_beats.push_back(b);
               end
            end
            default: ; // measurement while idle is dropped
         endcase
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      pts_pkg::rsp_type want;
      if (reset) begin
         full_min  = pts_pkg::FULL_SCALE_MIN_RST;
         zero_max  = pts_pkg::ZERO_SCALE_MAX_RST;
         win_high  = pts_pkg::WINDOW_HIGH_RST;
         win_low   = pts_pkg::WINDOW_LOW_RST;
         cal_phase = CAL_IDLE;
         lo_bound  = 32'd1;
         hi_bound  = MAX_CODE;
         probe     = '0;
         expected_beats.delete();
      end else begin
         // result side first: this beat belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("kind: expected no beat, got %0d", rsp_data.kind);
               faults++;
            end else begin
               want = expected_beats.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
               check_field("pot_code", 32'(want.pot_code), 32'(rsp_data.pot_code));
               check_field("reported_value", 32'(want.reported_value),
                           32'(rsp_data.reported_value));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("trim_code", 32'(want.trim_code), 32'(rsp_data.trim_code));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (csr_we) begin
            case (csr_index)
               pts_pkg::REG_FULL_SCALE_MIN: full_min = csr_wdata;
               pts_pkg::REG_ZERO_SCALE_MAX: zero_max = csr_wdata;
               pts_pkg::REG_WINDOW_HIGH:    win_high = csr_wdata;
               pts_pkg::REG_WINDOW_LOW:     win_low  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_trim_step(req_data);
      end
      beats_pending <= expected_beats.size();
   end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for pot_trim_binary_search_top: directed calibrations,
// then random ones across several register settings. Uses pts_pkg and trim_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_BEATS = 240;
   localparam int unsigned VW          = pts_pkg::VALUE_W;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pts_pkg::req_type    req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   pts_pkg::rsp_type    rsp_data;
   logic                csr_we    = 1'b0;
   logic [1:0]          csr_index = pts_pkg::REG_FULL_SCALE_MIN;
   logic [VW-1:0]       csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned beats_pending;
   int unsigned cycle_count = 0;
   int unsigned beats_sent  = 0;
   logic        calm        = 1'b0;

   // Register values as last written
   logic [VW-1:0] fs_min = pts_pkg::FULL_SCALE_MIN_RST;
   logic [VW-1:0] zs_max = pts_pkg::ZERO_SCALE_MAX_RST;
   logic [VW-1:0] w_high = pts_pkg::WINDOW_HIGH_RST;
   logic [VW-1:0] w_low  = pts_pkg::WINDOW_LOW_RST;

   always #6 clock = ~clock;

   pot_trim_binary_search_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   trim_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .beats_pending  (beats_pending)
   );

   // Result side back-pressure
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !calm && ($urandom_range(0, 99) < 9);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One request beat, with an optional random gap in front
   task automatic send_beat(input logic action, input logic [VW-1:0] value);
      pts_pkg::req_type r;
      r.action         = action;
      r.measured_value = value;
      @(negedge clock);
      while (!calm && ($urandom_range(0, 99) < 9)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // Drop valid and let every expected beat drain, plus the pipeline depth
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (beats_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_regs(input logic [VW-1:0] fs, input logic [VW-1:0] zs,
                             input logic [VW-1:0] wh, input logic [VW-1:0] wl);
      drain();
      csr_we <= 1'b1; csr_index <= pts_pkg::REG_FULL_SCALE_MIN; csr_wdata <= fs;
      @(negedge clock);
      csr_index <= pts_pkg::REG_ZERO_SCALE_MAX; csr_wdata <= zs;
      @(negedge clock);
      csr_index <= pts_pkg::REG_WINDOW_HIGH; csr_wdata <= wh;
      @(negedge clock);
      csr_index <= pts_pkg::REG_WINDOW_LOW; csr_wdata <= wl;
      @(negedge clock);
      csr_we <= 1'b0;
      fs_min = fs; zs_max = zs; w_high = wh; w_low = wl;
   endtask

   // Reading for a search step: 0 high, 1 low, 2 inside the window (any value if it is empty)
   function automatic logic [VW-1:0] search_reading(input int unsigned cls);
      int unsigned hi, lo;
      hi = 32'(w_high);
      lo = 32'(w_low);
      case (cls)
         0:       return VW'($urandom_range(hi, 65535));
         1:       return VW'($urandom_range(0, lo));
         default: begin
            if (hi > lo + 1) return VW'($urandom_range(lo + 1, hi - 1));
            return VW'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // One random calibration: mostly well formed, sometimes cut short or noise
   task automatic run_calibration();
      int unsigned n_search, pick;
      logic [VW-1:0] v;
      if ($urandom_range(0, 99) < 5) begin
         send_beat(1'($urandom_range(0, 1)), VW'($urandom_range(0, 65535)));
         return;
      end
      send_beat(pts_pkg::ACT_START, '0);
      if ($urandom_range(0, 99) < 85 || fs_min == '0)
         v = VW'($urandom_range(int'(fs_min), 65535));
      else
         v = VW'($urandom_range(0, int'(fs_min) - 1));
      send_beat(pts_pkg::ACT_MEASURE, v);
      if ($urandom_range(0, 99) < 85 || zs_max == 16'hFFFF)
         v = VW'($urandom_range(0, int'(zs_max)));
      else
         v = VW'($urandom_range(int'(zs_max) + 1, 65535));
      send_beat(pts_pkg::ACT_MEASURE, v);
      n_search = $urandom_range(1, 12);
      for (int i = 0; i < n_search; i++) begin
         // abandoned run: the next start restarts a busy search
         if ($urandom_range(0, 99) < 4) return;
         pick = $urandom_range(0, 99);
         send_beat(pts_pkg::ACT_MEASURE,
                   search_reading(pick < 45 ? 0 : (pick < 90 ? 1 : 2)));
      end
   endtask

   initial begin
      int unsigned phase_end;
      int unsigned wl_pick, zs_pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, default registers
      send_beat(pts_pkg::ACT_MEASURE, 16'd0);        // ignored while idle
      send_beat(pts_pkg::ACT_START, 16'hFFFF);
      send_beat(pts_pkg::ACT_MEASURE, 16'd3999);     // full scale low
      send_beat(pts_pkg::ACT_START, 16'd0);
      send_beat(pts_pkg::ACT_MEASURE, 16'hFFFF);
      send_beat(pts_pkg::ACT_MEASURE, 16'd1001);     // zero scale high
      send_beat(pts_pkg::ACT_START, 16'd0);
      send_beat(pts_pkg::ACT_MEASURE, 16'd4000);     // thresholds are inclusive
      send_beat(pts_pkg::ACT_MEASURE, 16'd1000);
      send_beat(pts_pkg::ACT_MEASURE, 16'd2600);     // high edge of window
      send_beat(pts_pkg::ACT_MEASURE, 16'd2400);     // low edge of window
      send_beat(pts_pkg::ACT_MEASURE, 16'd2500);     // inside: success
      send_beat(pts_pkg::ACT_START, 16'd0);
      send_beat(pts_pkg::ACT_START, 16'd0);          // restart while busy
      send_beat(pts_pkg::ACT_MEASURE, 16'd5000);
      send_beat(pts_pkg::ACT_MEASURE, 16'd0);
      // always high: bounds close down to one and two, then fail
      for (int i = 0; i < 9; i++) send_beat(pts_pkg::ACT_MEASURE, 16'hFFFF);

      // Random phases over several register settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_regs(pts_pkg::FULL_SCALE_MIN_RST, pts_pkg::ZERO_SCALE_MAX_RST,
                          pts_pkg::WINDOW_HIGH_RST, pts_pkg::WINDOW_LOW_RST);
            1: write_regs(16'd0, 16'd0, 16'd0, 16'd0);
            2: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: begin
               // overlapping window: both tests can hold
               wl_pick = $urandom_range(100, 65535);
               write_regs(VW'($urandom_range(0, 65535)), VW'($urandom_range(0, 65535)),
                          VW'($urandom_range(0, wl_pick)), VW'(wl_pick));
            end
            default: begin
               zs_pick = $urandom_range(0, 30000);
               wl_pick = $urandom_range(0, 60000);
               write_regs(VW'($urandom_range(zs_pick, 65535)), VW'(zs_pick),
                          VW'($urandom_range(wl_pick + 2, 65535)), VW'(wl_pick));
            end
         endcase
         calm = (p == 4);
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) run_calibration();
      end
      calm = 1'b0;

      drain();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* pot_trim_binary_search_top.f */
sv/pts_pkg.sv
sv/pts_core.sv
sv/pts_out_buf.sv
sv/pot_trim_binary_search_top.sv
tb/trim_checker.sv
tb/tb_top.sv
